// ----- rtl/reciprocal_exp_gain_curve_macros.svh -----
// Assertion helpers for the gain curve top module.
`ifndef RECIPROCAL_EXP_GAIN_CURVE_MACROS_SVH
`define RECIPROCAL_EXP_GAIN_CURVE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define REGC_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define REGC_CHECK_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/regc_pkg.sv -----
package regc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MW = 64;

   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   localparam logic [7:0] REG_FLOOR   = 8'd0;
   localparam logic [7:0] REG_CEILING = 8'd1;
   localparam logic [7:0] REG_SLOPE   = 8'd2;
   localparam logic [7:0] REG_CENTER  = 8'd3;

   typedef struct packed {
      logic fallback;
      logic neg_x;
      logic tiny_m;
   } div_tag_type;

   typedef struct packed {
      logic              fallback;
      logic signed [7:0] pow;
      logic [1:0]        idx;
   } exp_tag_type;

   // 2^(i/4) in Q30
   function automatic logic [30:0] pow2_quarter(input logic [1:0] i);
      logic [30:0] v;
      case (i)
         2'd0:    v = 31'd1073741824;
         2'd1:    v = 31'd1276901417;
         2'd2:    v = 31'd1518500250;
         2'd3:    v = 31'd1805811301;
         default: v = 31'd1073741824;
      endcase
      return v;
   endfunction

   // floor(v / k) = (v * recip_mul(k)) >> recip_shift(k), exact for v < 2^32
   function automatic logic [31:0] recip_mul(input int k);
      logic [31:0] v;
      case (k)
         3:       v = 32'hAAAAAAAB;
         5:       v = 32'hCCCCCCCD;
         default: v = 32'd1;
      endcase
      return v;
   endfunction

   function automatic int recip_shift(input int k);
      int v;
      case (k)
         2:       v = 1;
         3:       v = 33;
         4:       v = 2;
         5:       v = 34;
         default: v = 0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/regc_div_cell.sv -----
module regc_div_cell #(
   parameter int QW = 23
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [regc_pkg::MW-1:0]  in_r,
   input  logic [regc_pkg::MW-1:0]  in_m,
   input  logic [QW-1:0]            in_q,
   input  regc_pkg::div_tag_type    in_tag,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [regc_pkg::MW-1:0]  out_r,
   output logic [regc_pkg::MW-1:0]  out_m,
   output logic [QW-1:0]            out_q,
   output regc_pkg::div_tag_type    out_tag
);

   logic                    v_ff, v_in;
   logic [regc_pkg::MW-1:0] r_ff, r_in, m_ff, m_in;
   logic [QW-1:0]           q_ff, q_in;
   regc_pkg::div_tag_type   tag_ff, tag_in;
   logic [regc_pkg::MW-1:0] r_sh;
   logic                    ge;

   assign in_ready = !v_ff | out_ready;

   // one restoring step; the remainder stays below the divisor if it entered below it
   always_comb begin
      r_sh   = {in_r[regc_pkg::MW-2:0], 1'b0};
      ge     = r_sh >= in_m;
      r_in   = ge ? r_sh - in_m : r_sh;
      q_in   = {in_q[QW-2:0], ge};
      m_in   = in_m;
      tag_in = in_tag;
      v_in   = in_ready ? in_valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         r_ff   <= r_in;
         m_ff   <= m_in;
         q_ff   <= q_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = v_ff;
   assign out_r     = r_ff;
   assign out_m     = m_ff;
   assign out_q     = q_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- rtl/regc_poly_cell.sv -----
module regc_poly_cell #(
   parameter int KDIV = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [30:0]           in_p,
   input  logic [27:0]           in_u,
   input  regc_pkg::exp_tag_type in_tag,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [30:0]           out_p,
   output logic [27:0]           out_u,
   output regc_pkg::exp_tag_type out_tag
);

   localparam logic [31:0] RM = regc_pkg::recip_mul(KDIV);
   localparam int          RS = regc_pkg::recip_shift(KDIV);

   logic                  va_ff, va_in, vb_ff, vb_in, rdy_b;
   logic [28:0]           w_ff, w_in;
   logic [27:0]           ua_ff, ua_in, ub_ff, ub_in;
   regc_pkg::exp_tag_type ta_ff, ta_in, tb_ff, tb_in;
   logic [30:0]           p_ff, p_in;
   logic [58:0]           pu;
   logic [60:0]           hw;

   assign rdy_b    = !vb_ff | out_ready;
   assign in_ready = !va_ff | rdy_b;

   // first half: p*u, second half: divide by k through its reciprocal, add 1.0
   always_comb begin
      pu    = 59'(in_p) * 59'(in_u);
      w_in  = pu[58:30];
      ua_in = in_u;
      ta_in = in_tag;
      hw    = 61'(w_ff) * 61'(RM);
      p_in  = regc_pkg::ONE_Q30 + 31'(hw >> RS);
      ub_in = ua_ff;
      tb_in = ta_ff;
      va_in = in_ready ? in_valid : va_ff;
      vb_in = rdy_b ? va_ff : vb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) begin
         w_ff  <= w_in;
         ua_ff <= ua_in;
         ta_ff <= ta_in;
      end
      if (rdy_b & va_ff) begin
         p_ff  <= p_in;
         ub_ff <= ub_in;
         tb_ff <= tb_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_p     = p_ff;
   assign out_u     = ub_ff;
   assign out_tag   = tb_ff;

endmodule

// ----- rtl/reciprocal_exp_gain_curve.sv -----
// Gain scheduling curve f(t) = A + (K - A) * exp(-1 / (B * (t - c))), Q16.16.
// Request channel: req_valid/req_ready with req_operating_point (t).
// Response channel: rsp_valid/rsp_ready with rsp_gain_value, rsp_saturated
// and rsp_fell_back. CSR channel: csr_valid/csr_ready (always ready) with
// csr_index 0..3 = A, K, B, c and csr_data; other indexes are ignored.
// Write CSRs only while no request is in flight.
// Pipeline, for Q16.16 or any FRAC_BITS: two front stages, one
// restoring-division cell per quotient bit (3*FRAC_BITS cells), three
// stages for the log2e scaling and ln2 fraction, five two-stage polynomial
// cells, then mantissa, scale, rounding and output stages.
// Throughput is one request per cycle while rsp_ready holds; every stage
// has its own valid bit and a stage accepts whenever it is empty or moving,
// so bubbles close up and the request side keeps loading while a response waits.
// A stalled receiver fills the pipe until req_ready drops; nothing is lost.
// Synchronous reset empties the pipe and clears A, K, B and c to zero.
`include "reciprocal_exp_gain_curve_macros.svh"

module reciprocal_exp_gain_curve #(
   parameter int FRAC_BITS = regc_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operating_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_gain_value,
   output logic        rsp_saturated,
   output logic        rsp_fell_back,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int QW       = FRAC_BITS + 7;
   localparam int NDIV     = 3 * FRAC_BITS;
   localparam int SHIFT_X  = 32 - FRAC_BITS;
   localparam int SMALL_SH = 2 * FRAC_BITS - 6;
   localparam int XW       = QW + SHIFT_X;
   localparam int MW       = regc_pkg::MW;

   // ---------------- CSRs
   logic [31:0] floor_ff, floor_in, ceil_ff, ceil_in;
   logic [31:0] slope_ff, slope_in, center_ff, center_in;

   assign csr_ready = 1'b1;

   always_comb begin
      floor_in  = floor_ff;
      ceil_in   = ceil_ff;
      slope_in  = slope_ff;
      center_in = center_ff;
      if (csr_valid) begin
         case (csr_index)
            regc_pkg::REG_FLOOR:   floor_in  = csr_data;
            regc_pkg::REG_CEILING: ceil_in   = csr_data;
            regc_pkg::REG_SLOPE:   slope_in  = csr_data;
            regc_pkg::REG_CENTER:  center_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff  <= '0;
         ceil_ff   <= '0;
         slope_ff  <= '0;
         center_ff <= '0;
      end else begin
         floor_ff  <= floor_in;
         ceil_ff   <= ceil_in;
         slope_ff  <= slope_in;
         center_ff <= center_in;
      end
   end

   // K - A; the user must keep it stable while requests are in flight (not enforced)
   logic [32:0] kdiff, kdiff_mag;
   logic        kdiff_neg;
   assign kdiff     = {ceil_ff[31], ceil_ff} - {floor_ff[31], floor_ff};
   assign kdiff_neg = kdiff[32];
   assign kdiff_mag = kdiff_neg ? -kdiff : kdiff;

   // ---------------- handshake chain
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
   logic d_vld [0:NDIV];
   logic d_rdy [0:NDIV];
   logic p_vld [0:5];
   logic p_rdy [0:5];

   assign rdy8 = !v8_ff | rsp_ready;
   assign rdy7 = !v7_ff | rdy8;
   assign rdy6 = !v6_ff | rdy7;
   assign rdy5 = !v5_ff | rdy6;
   assign p_rdy[5] = rdy5;
   assign rdy4 = !v4_ff | p_rdy[0];
   assign rdy3 = !v3_ff | rdy4;
   assign rdy2 = !v2_ff | rdy3;
   assign d_rdy[NDIV] = rdy2;
   assign rdy1 = !v1_ff | d_rdy[0];
   assign rdy0 = !v0_ff | rdy1;
   assign req_ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= d_vld[NDIV];
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= p_vld[5];
         if (rdy6) v6_ff <= v5_ff;
         if (rdy7) v7_ff <= v6_ff;
         if (rdy8) v8_ff <= v7_ff;
      end
   end

   // ---------------- stage 0: d = t - c
   logic [32:0] d0_ff, d0_in;
   logic        fb0_ff, fb0_in, neg0_ff, neg0_in;

   always_comb begin
      d0_in   = {req_operating_point[31], req_operating_point} -
                {center_ff[31], center_ff};
      fb0_in  = (slope_ff == '0) | (d0_in == '0);
      neg0_in = slope_ff[31] == d0_in[32];
   end

   always_ff @(posedge clock) begin
      if (rdy0 & req_valid) begin
         d0_ff   <= d0_in;
         fb0_ff  <= fb0_in;
         neg0_ff <= neg0_in;
      end
   end

   // ---------------- stage 1: m = |B| * |d|
   logic [MW-1:0] m1_ff, m1_in;
   logic          fb1_ff, neg1_ff;
   logic [31:0]   bmag;
   logic [32:0]   dmag;

   always_comb begin
      bmag  = slope_ff[31] ? -slope_ff : slope_ff;
      dmag  = d0_ff[32] ? -d0_ff : d0_ff;
      m1_in = MW'(bmag) * MW'(dmag);
   end

   always_ff @(posedge clock) begin
      if (rdy1 & v0_ff) begin
         m1_ff   <= m1_in;
         fb1_ff  <= fb0_ff;
         neg1_ff <= neg0_ff;
      end
   end

   // ---------------- division chain: q = floor(2^(3F) / m)
   logic [MW-1:0]         d_r   [0:NDIV];
   logic [MW-1:0]         d_m   [0:NDIV];
   logic [QW-1:0]         d_q   [0:NDIV];
   regc_pkg::div_tag_type d_tag [0:NDIV];

   assign d_vld[0] = v1_ff;
   assign d_r[0]   = MW'(1);
   assign d_m[0]   = m1_ff;
   assign d_q[0]   = '0;
   assign d_tag[0] = '{fallback: fb1_ff, neg_x: neg1_ff,
                       tiny_m: (m1_ff >> SMALL_SH) == '0};

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      regc_div_cell #(.QW(QW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (d_vld[i]),
         .in_ready (d_rdy[i]),
         .in_r     (d_r[i]),
         .in_m     (d_m[i]),
         .in_q     (d_q[i]),
         .in_tag   (d_tag[i]),
         .out_valid(d_vld[i+1]),
         .out_ready(d_rdy[i+1]),
         .out_r    (d_r[i+1]),
         .out_m    (d_m[i+1]),
         .out_q    (d_q[i+1]),
         .out_tag  (d_tag[i+1])
      );
   end

   // ---------------- stage 2: signed exponent in Q32
   logic signed [XW:0] x2_ff, x2_in;
   logic               fb2_ff;
   logic [QW-1:0]      xmag;
   logic [XW-1:0]      xq32;

   always_comb begin
      xmag  = d_tag[NDIV].tiny_m ? (QW'(1) << (FRAC_BITS + 6)) : d_q[NDIV];
      xq32  = {xmag, {SHIFT_X{1'b0}}};
      x2_in = d_tag[NDIV].neg_x ? -$signed({1'b0, xq32}) : $signed({1'b0, xq32});
   end

   always_ff @(posedge clock) begin
      if (rdy2 & d_vld[NDIV]) begin
         x2_ff  <= x2_in;
         fb2_ff <= d_tag[NDIV].fallback;
      end
   end

   // ---------------- stage 3: Y = x * log2 e (Q24 constant, floor by bit drop)
   logic signed [63:0] y3_ff, y3_in;
   logic               fb3_ff;

   assign y3_in = 64'(x2_ff) * 64'($signed({1'b0, regc_pkg::LOG2E_Q24}));

   always_ff @(posedge clock) begin
      if (rdy3 & v2_ff) begin
         y3_ff  <= y3_in;
         fb3_ff <= fb2_ff;
      end
   end

   // ---------------- stage 4: u = g * ln2, integer part and table index
   logic [27:0]           u4_ff, u4_in;
   regc_pkg::exp_tag_type tag4_ff, tag4_in;
   logic [61:0]           gl;

   always_comb begin
      gl      = 62'(y3_ff[53:24]) * 62'(regc_pkg::LN2_Q32);
      u4_in   = gl[61:34];
      tag4_in = '{fallback: fb3_ff, pow: y3_ff[63:56], idx: y3_ff[55:54]};
   end

   always_ff @(posedge clock) begin
      if (rdy4 & v3_ff) begin
         u4_ff   <= u4_in;
         tag4_ff <= tag4_in;
      end
   end

   // ---------------- Horner cells, k = 5 down to 1
   logic [30:0]           p_p   [0:5];
   logic [27:0]           p_u   [0:5];
   regc_pkg::exp_tag_type p_tag [0:5];

   assign p_vld[0] = v4_ff;
   assign p_p[0]   = regc_pkg::ONE_Q30;
   assign p_u[0]   = u4_ff;
   assign p_tag[0] = tag4_ff;

   for (genvar i = 0; i < 5; i++) begin : g_poly
      regc_poly_cell #(.KDIV(5 - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (p_vld[i]),
         .in_ready (p_rdy[i]),
         .in_p     (p_p[i]),
         .in_u     (p_u[i]),
         .in_tag   (p_tag[i]),
         .out_valid(p_vld[i+1]),
         .out_ready(p_rdy[i+1]),
         .out_p    (p_p[i+1]),
         .out_u    (p_u[i+1]),
         .out_tag  (p_tag[i+1])
      );
   end

   // ---------------- stage 5: mantissa e = 2^(i/4) * p
   logic [31:0]           e5_ff, e5_in;
   regc_pkg::exp_tag_type tag5_ff;
   logic [61:0]           tp;

   always_comb begin
      tp    = 62'(regc_pkg::pow2_quarter(p_tag[5].idx)) * 62'(p_p[5]);
      e5_in = tp[61:30];
   end

   always_ff @(posedge clock) begin
      if (rdy5 & p_vld[5]) begin
         e5_ff   <= e5_in;
         tag5_ff <= p_tag[5];
      end
   end

   // ---------------- stage 6: P = |K - A| * e
   logic [63:0]           pr6_ff, pr6_in;
   regc_pkg::exp_tag_type tag6_ff;

   assign pr6_in = 64'(kdiff_mag) * 64'(e5_ff);

   always_ff @(posedge clock) begin
      if (rdy6 & v5_ff) begin
         pr6_ff  <= pr6_in;
         tag6_ff <= tag5_ff;
      end
   end

   // ---------------- stage 7: scale by 2^(n-30), round half up; flag overflow for n >= 30 and nonzero P
   logic [63:0]        term7_ff, term7_in;
   logic               huge7_ff, huge7_in, fb7_ff;
   logic signed [9:0]  s_w;
   logic [5:0]         sh;
   logic [64:0]        rsum;

   always_comb begin
      s_w      = 10'sd30 - $signed({{2{tag6_ff.pow[7]}}, tag6_ff.pow});
      sh       = s_w[5:0];
      rsum     = {1'b0, pr6_ff} + (65'd1 << (sh - 6'd1));
      term7_in = '0;
      huge7_in = 1'b0;
      if (s_w > 10'sd63) begin
         term7_in = '0;
      end else if (s_w > 10'sd0) begin
         term7_in = 64'(rsum >> sh);
      end else begin
         huge7_in = pr6_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7 & v6_ff) begin
         term7_ff <= term7_in;
         huge7_ff <= huge7_in;
         fb7_ff   <= tag6_ff.fallback;
      end
   end

   // ---------------- stage 8: add to A or pass A on fallback, clamp, response register
   logic [31:0]        gain_ff, gain_in;
   logic               sat_ff, sat_in, fb8_ff;
   logic signed [65:0] res, a66, t66;

   always_comb begin
      a66     = $signed({{34{floor_ff[31]}}, floor_ff});
      t66     = $signed({2'b00, term7_ff});
      res     = kdiff_neg ? a66 - t66 : a66 + t66;
      gain_in = res[31:0];
      sat_in  = 1'b0;
      if (fb7_ff) begin
         gain_in = floor_ff;
      end else if (huge7_ff) begin
         gain_in = kdiff_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         sat_in  = 1'b1;
      end else if (res > 66'sh0_7FFF_FFFF) begin
         gain_in = 32'h7FFF_FFFF;
         sat_in  = 1'b1;
      end else if (res < -66'sh0_8000_0000) begin
         gain_in = 32'h8000_0000;
         sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy8 & v7_ff) begin
         gain_ff <= gain_in;
         sat_ff  <= sat_in;
         fb8_ff  <= fb7_ff;
      end
   end

   assign rsp_valid      = v8_ff;
   assign rsp_gain_value = gain_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_fell_back  = fb8_ff;

   // ---------------- checks
   `REGC_CHECK(a_fb_not_sat, !(rsp_valid & rsp_fell_back & rsp_saturated),
      "fallback saturated")
   `REGC_CHECK(a_fb_floor,
      !(rsp_valid & rsp_fell_back) || (rsp_gain_value == floor_ff), "fallback not A")
   `REGC_CHECK(a_sat_limit, !(rsp_valid & rsp_saturated) ||
      (rsp_gain_value == 32'h7FFF_FFFF) || (rsp_gain_value == 32'h8000_0000),
      "saturated off limit")
   `REGC_CHECK_NEXT(a_huge_sat, v7_ff & rdy8 & huge7_ff & !fb7_ff, rsp_saturated,
      "huge exponent lost")

endmodule
